[design/dwpd_pkg.sv]
// dwpd_pkg: shared types, widths, register indexes and microcode encoding
// for the dual wheel pid drive unit
// no dependencies
package dwpd_pkg;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // sizing
    localparam int COUNT_BITS = 10;
    localparam int ACCUM_BITS = 24;

    localparam int ERR_W     = COUNT_BITS + 1;
    localparam int DIFF_W    = COUNT_BITS + 2;
    localparam int DB_W      = 8;
    localparam int MAG_W     = max2(ERR_W, DB_W);
    localparam int GAIN_W    = 16;
    localparam int DUTY_W    = 14;
    localparam int DRIVE_W   = 15;
    localparam int FRAC_BITS = 16;
    localparam int ONE_Q16   = 65536;
    localparam int UNIT_W    = FRAC_BITS + 1;

    // shared multiplier and accumulator
    localparam int MA_W   = GAIN_W + 1;
    localparam int MB_W   = max2(max2(ACCUM_BITS, DIFF_W), UNIT_W + 2);
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SAT_W  = max2(ACCUM_BITS, ERR_W) + 1;

    localparam logic signed [SAT_W-1:0] ACC_HI =
        {{(SAT_W - ACCUM_BITS + 1){1'b0}}, {(ACCUM_BITS - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] ACC_LO = ~ACC_HI;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY    = 3'd5;

    localparam logic [COUNT_BITS-1:0] RST_TARGET_COUNT = COUNT_BITS'(50);
    localparam logic [DB_W-1:0]       RST_DEADBAND     = 8'd3;
    localparam logic [GAIN_W-1:0]     RST_GAIN_P       = 16'd1966;
    localparam logic [GAIN_W-1:0]     RST_GAIN_I       = 16'd328;
    localparam logic [GAIN_W-1:0]     RST_GAIN_D       = 16'd9830;
    localparam logic [DUTY_W-1:0]     RST_BASE_DUTY    = 14'd6000;

    // microcode encoding
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UPC_LAST = 4'd13;

    localparam logic [1:0] MUL_P     = 2'd0;
    localparam logic [1:0] MUL_D     = 2'd1;
    localparam logic [1:0] MUL_I     = 2'd2;
    localparam logic [1:0] MUL_DRIVE = 2'd3;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_CLAMP = 2'd1;
    localparam logic [1:0] ACC_ADD   = 2'd2;

    typedef struct packed {
        logic       side;
        logic [1:0] mul_sel;
        logic       mul_en;
        logic [1:0] acc_op;
        logic       commit;
        logic       skip_if_hold;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic run;
        uop_t uop;
    } seq_ctrl_t;

    typedef struct packed {
        logic               adjust_now;
        logic               adjusted;
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
    } dp_stat_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] target_count;
        logic [DB_W-1:0]       deadband;
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [DUTY_W-1:0]     base_duty;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] left_ticks;
        logic [COUNT_BITS-1:0] right_ticks;
    } in_beat_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
        logic               adjusted;
    } out_beat_t;

    // clamp a q16 value to [0, 1.0]
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] one;
        one = SUM_W'(ONE_Q16);
        if (v < 0) begin
            return '0;
        end else if (v > one) begin
            return UNIT_W'(ONE_Q16);
        end else begin
            return v[UNIT_W-1:0];
        end
    endfunction

endpackage

[design/dwpd_useq.sv]
// dwpd_useq: microcode sequencer, program rom plus step counter
// depends on dwpd_pkg
module dwpd_useq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                adjust_now,
    input  logic                out_free,
    output dwpd_pkg::seq_ctrl_t ctrl
);

    function automatic dwpd_pkg::uop_t mk(
        input logic       side,
        input logic [1:0] mul_sel,
        input logic       mul_en,
        input logic [1:0] acc_op,
        input logic       commit,
        input logic       skip_if_hold,
        input logic       last
    );
        dwpd_pkg::uop_t u;
        u.side         = side;
        u.mul_sel      = mul_sel;
        u.mul_en       = mul_en;
        u.acc_op       = acc_op;
        u.commit       = commit;
        u.skip_if_hold = skip_if_hold;
        u.last         = last;
        return u;
    endfunction

    // per side: p, clamp p / d, add d / i, add i, drive multiply, commit
    function automatic dwpd_pkg::uop_t rom(input logic [dwpd_pkg::UPC_W-1:0] a);
        dwpd_pkg::uop_t u;
        unique case (a)
            4'd0:  u = mk(1'b0, dwpd_pkg::MUL_P, 1'b0, dwpd_pkg::ACC_NONE, 1'b0, 1'b1, 1'b0);
            4'd1:  u = mk(1'b0, dwpd_pkg::MUL_P, 1'b1, dwpd_pkg::ACC_NONE, 1'b0, 1'b0, 1'b0);
            4'd2:  u = mk(1'b0, dwpd_pkg::MUL_D, 1'b1, dwpd_pkg::ACC_CLAMP, 1'b0, 1'b0, 1'b0);
            4'd3:  u = mk(1'b0, dwpd_pkg::MUL_I, 1'b1, dwpd_pkg::ACC_ADD, 1'b0, 1'b0, 1'b0);
            4'd4:  u = mk(1'b0, dwpd_pkg::MUL_I, 1'b0, dwpd_pkg::ACC_ADD, 1'b0, 1'b0, 1'b0);
            4'd5:  u = mk(1'b0, dwpd_pkg::MUL_DRIVE, 1'b1, dwpd_pkg::ACC_NONE, 1'b0, 1'b0, 1'b0);
            4'd6:  u = mk(1'b0, dwpd_pkg::MUL_P, 1'b0, dwpd_pkg::ACC_NONE, 1'b1, 1'b0, 1'b0);
            4'd7:  u = mk(1'b1, dwpd_pkg::MUL_P, 1'b1, dwpd_pkg::ACC_NONE, 1'b0, 1'b0, 1'b0);
            4'd8:  u = mk(1'b1, dwpd_pkg::MUL_D, 1'b1, dwpd_pkg::ACC_CLAMP, 1'b0, 1'b0, 1'b0);
            4'd9:  u = mk(1'b1, dwpd_pkg::MUL_I, 1'b1, dwpd_pkg::ACC_ADD, 1'b0, 1'b0, 1'b0);
            4'd10: u = mk(1'b1, dwpd_pkg::MUL_I, 1'b0, dwpd_pkg::ACC_ADD, 1'b0, 1'b0, 1'b0);
            4'd11: u = mk(1'b1, dwpd_pkg::MUL_DRIVE, 1'b1, dwpd_pkg::ACC_NONE, 1'b0, 1'b0, 1'b0);
            4'd12: u = mk(1'b1, dwpd_pkg::MUL_P, 1'b0, dwpd_pkg::ACC_NONE, 1'b1, 1'b0, 1'b0);
            4'd13: u = mk(1'b0, dwpd_pkg::MUL_P, 1'b0, dwpd_pkg::ACC_NONE, 1'b0, 1'b0, 1'b1);
            default: u = '0;
        endcase
        return u;
    endfunction

    logic                      busy_reg, busy_next;
    logic [dwpd_pkg::UPC_W-1:0] upc_reg, upc_next;
    dwpd_pkg::uop_t            uop;

    assign uop       = rom(upc_reg);
    assign ctrl.run  = busy_reg;
    assign ctrl.uop  = uop;

    always_comb begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                upc_next  = '0;
            end
        end else if (uop.last) begin
            if (out_free) begin
                busy_next = 1'b0;
            end
        end else if (uop.skip_if_hold && !adjust_now) begin
            upc_next = dwpd_pkg::UPC_LAST;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

endmodule

[design/dwpd_datapath.sv]
// dwpd_datapath: error terms, shared multiplier, accumulator and per side state
// depends on dwpd_pkg
module dwpd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  dwpd_pkg::in_beat_t  in_beat,
    input  dwpd_pkg::cfg_t      cfg,
    input  dwpd_pkg::seq_ctrl_t ctrl,
    output dwpd_pkg::dp_stat_t  stat
);

    logic [dwpd_pkg::COUNT_BITS-1:0] left_ticks_reg, right_ticks_reg;
    logic                            adjust_reg;
    logic signed [dwpd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [dwpd_pkg::SUM_W-1:0]  acc_reg, acc_next;

    logic signed [dwpd_pkg::ERR_W-1:0]      prev_l_reg, prev_r_reg;
    logic signed [dwpd_pkg::ACCUM_BITS-1:0] total_l_reg, total_r_reg, total_next;
    logic [dwpd_pkg::DRIVE_W-1:0]           held_l_reg, held_r_reg;

    logic signed [dwpd_pkg::ERR_W-1:0]      err_l, err_r, err_sel, prev_sel;
    logic signed [dwpd_pkg::ERR_W-1:0]      neg_l, neg_r;
    logic [dwpd_pkg::MAG_W-1:0]             mag_l, mag_r;
    logic signed [dwpd_pkg::ACCUM_BITS-1:0] total_sel;
    logic signed [dwpd_pkg::DIFF_W-1:0]     diff;
    logic signed [dwpd_pkg::SAT_W-1:0]      total_wide;
    logic [dwpd_pkg::UNIT_W:0]              unit_sum;
    logic signed [dwpd_pkg::MA_W-1:0]       mul_a;
    logic signed [dwpd_pkg::MB_W-1:0]       mul_b;
    logic                                   active;

    assign active = ctrl.run;

    // errors, target minus count
    assign err_l = $signed({1'b0, cfg.target_count}) - $signed({1'b0, left_ticks_reg});
    assign err_r = $signed({1'b0, cfg.target_count}) - $signed({1'b0, right_ticks_reg});
    assign neg_l = -err_l;
    assign neg_r = -err_r;
    assign mag_l = err_l[dwpd_pkg::ERR_W-1] ? dwpd_pkg::MAG_W'(unsigned'(neg_l))
                                            : dwpd_pkg::MAG_W'(unsigned'(err_l));
    assign mag_r = err_r[dwpd_pkg::ERR_W-1] ? dwpd_pkg::MAG_W'(unsigned'(neg_r))
                                            : dwpd_pkg::MAG_W'(unsigned'(err_r));

    assign stat.adjust_now  = (mag_l > dwpd_pkg::MAG_W'(cfg.deadband))
                           || (mag_r > dwpd_pkg::MAG_W'(cfg.deadband));
    assign stat.adjusted    = adjust_reg;
    assign stat.left_drive  = held_l_reg;
    assign stat.right_drive = held_r_reg;

    // side select
    assign err_sel   = ctrl.uop.side ? err_r : err_l;
    assign prev_sel  = ctrl.uop.side ? prev_r_reg : prev_l_reg;
    assign total_sel = ctrl.uop.side ? total_r_reg : total_l_reg;
    assign diff      = dwpd_pkg::DIFF_W'(err_sel) - dwpd_pkg::DIFF_W'(prev_sel);

    assign unit_sum = (dwpd_pkg::UNIT_W + 1)'(dwpd_pkg::ONE_Q16)
                    + {1'b0, dwpd_pkg::clamp_unit(acc_reg)};

    // operand select for the shared multiplier
    always_comb begin
        unique case (ctrl.uop.mul_sel)
            dwpd_pkg::MUL_P: begin
                mul_a = dwpd_pkg::MA_W'(cfg.gain_p);
                mul_b = dwpd_pkg::MB_W'(err_sel);
            end
            dwpd_pkg::MUL_D: begin
                mul_a = dwpd_pkg::MA_W'(cfg.gain_d);
                mul_b = dwpd_pkg::MB_W'(diff);
            end
            dwpd_pkg::MUL_I: begin
                mul_a = dwpd_pkg::MA_W'(cfg.gain_i);
                mul_b = dwpd_pkg::MB_W'(total_sel);
            end
            dwpd_pkg::MUL_DRIVE: begin
                mul_a = dwpd_pkg::MA_W'(cfg.base_duty);
                mul_b = dwpd_pkg::MB_W'(unit_sum);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        unique case (ctrl.uop.acc_op)
            dwpd_pkg::ACC_CLAMP:
                acc_next = dwpd_pkg::SUM_W'(dwpd_pkg::clamp_unit(dwpd_pkg::SUM_W'(prod_reg)));
            dwpd_pkg::ACC_ADD:
                acc_next = acc_reg + dwpd_pkg::SUM_W'(prod_reg);
            default:
                acc_next = acc_reg;
        endcase
    end

    // saturating error total
    always_comb begin
        total_wide = dwpd_pkg::SAT_W'(total_sel) + dwpd_pkg::SAT_W'(err_sel);
        if (total_wide > dwpd_pkg::ACC_HI) begin
            total_next = dwpd_pkg::ACCUM_BITS'(dwpd_pkg::ACC_HI);
        end else if (total_wide < dwpd_pkg::ACC_LO) begin
            total_next = dwpd_pkg::ACCUM_BITS'(dwpd_pkg::ACC_LO);
        end else begin
            total_next = total_wide[dwpd_pkg::ACCUM_BITS-1:0];
        end
    end

    // payload and scratch registers
    always_ff @(posedge aclk) begin
        if (load) begin
            left_ticks_reg  <= in_beat.left_ticks;
            right_ticks_reg <= in_beat.right_ticks;
        end
        if (active && ctrl.uop.mul_en) begin
            prod_reg <= prod_next;
        end
        if (active) begin
            acc_reg <= acc_next;
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adjust_reg  <= 1'b0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            total_l_reg <= '0;
            total_r_reg <= '0;
            held_l_reg  <= '0;
            held_r_reg  <= '0;
        end else if (active) begin
            if (ctrl.uop.skip_if_hold) begin
                adjust_reg <= stat.adjust_now;
            end
            if (ctrl.uop.commit) begin
                if (ctrl.uop.side) begin
                    held_r_reg  <= prod_reg[dwpd_pkg::FRAC_BITS+dwpd_pkg::DRIVE_W-1:
                                            dwpd_pkg::FRAC_BITS];
                    prev_r_reg  <= err_sel;
                    total_r_reg <= total_next;
                end else begin
                    held_l_reg  <= prod_reg[dwpd_pkg::FRAC_BITS+dwpd_pkg::DRIVE_W-1:
                                            dwpd_pkg::FRAC_BITS];
                    prev_l_reg  <= err_sel;
                    total_l_reg <= total_next;
                end
            end
        end
    end

endmodule

[design/dual_wheel_pid_drive_unit.sv]
// operation: the drives are recomputed only when an error lies outside the deadband;
// when both errors sit inside it the microprogram skips to its final step
// a beat is taken only once the previous result is in the output register, since the
// 14 step microprogram runs all products through one shared multiplier
// reset: synchronous active low aresetn; config registers take their defaults and all
// controller state (previous errors, totals, held drives) clears to zero
module dual_wheel_pid_drive_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dwpd_pkg::in_beat_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dwpd_pkg::out_beat_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dwpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dwpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dwpd_pkg::cfg_t      cfg_reg;
    dwpd_pkg::seq_ctrl_t ctrl;
    dwpd_pkg::dp_stat_t  stat;
    dwpd_pkg::out_beat_t m_data_reg;
    logic                m_valid_reg;
    logic                in_fire, out_free, out_load;

    // one beat in flight; the output register frees the sequencer early
    assign s_ready   = !ctrl.run;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = ctrl.run && ctrl.uop.last && out_free;
    assign cfg_ready = 1'b1;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_count <= dwpd_pkg::RST_TARGET_COUNT;
            cfg_reg.deadband     <= dwpd_pkg::RST_DEADBAND;
            cfg_reg.gain_p       <= dwpd_pkg::RST_GAIN_P;
            cfg_reg.gain_i       <= dwpd_pkg::RST_GAIN_I;
            cfg_reg.gain_d       <= dwpd_pkg::RST_GAIN_D;
            cfg_reg.base_duty    <= dwpd_pkg::RST_BASE_DUTY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dwpd_pkg::REG_TARGET_COUNT:
                    cfg_reg.target_count <= cfg_data[dwpd_pkg::COUNT_BITS-1:0];
                dwpd_pkg::REG_DEADBAND:  cfg_reg.deadband  <= cfg_data[dwpd_pkg::DB_W-1:0];
                dwpd_pkg::REG_GAIN_P:    cfg_reg.gain_p    <= cfg_data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_GAIN_I:    cfg_reg.gain_i    <= cfg_data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_GAIN_D:    cfg_reg.gain_d    <= cfg_data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_BASE_DUTY: cfg_reg.base_duty <= cfg_data[dwpd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // step counter and program rom
    dwpd_useq u_useq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_fire),
        .adjust_now (stat.adjust_now),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // arithmetic and controller state
    dwpd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_fire),
        .in_beat (s_data),
        .cfg     (cfg_reg),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    // result register: payload has no reset
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.left_drive  <= stat.left_drive;
            m_data_reg.right_drive <= stat.right_drive;
            m_data_reg.adjusted    <= stat.adjusted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTH
    // an accepted beat closes the input until its result is out
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while sequencer busy");

    // a result beat appears only from the final microcode step
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl.run && ctrl.uop.last))
        else $error("result beat raised outside final step");

    // a taken result with nothing behind it empties the output register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !out_load) |=> !m_valid)
        else $error("result beat repeated");
`endif

endmodule

[test/dual_wheel_pid_drive_unit_tb.sv]
// dual_wheel_pid_drive_unit_tb: self-checking bench for the two wheel pid drive unit,
// with a bit-exact drive predictor in a small class and plain tasks on the handshakes
// depends on dwpd_pkg and dual_wheel_pid_drive_unit
module dual_wheel_pid_drive_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_MAX      = (1 << dwpd_pkg::COUNT_BITS) - 1;
    localparam int SETTLE_CYCLES = 24;      // well past the adjust latency
    localparam int CYCLE_LIMIT   = 3000000; // several times the slowest legal run
    localparam int REPORT_MAX    = 10;
    localparam int LEFT          = 0;
    localparam int RIGHT         = 1;

    // indexes past the register map, writes there must be dropped
    localparam logic [dwpd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [dwpd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    // tracks the controller state and holds the drive beats still owed by the block
    class wheel_drive_book_t;
        dwpd_pkg::cfg_t               regs;
        longint                       prev_err [2];
        longint                       err_total [2];
        logic [dwpd_pkg::DRIVE_W-1:0] held [2];
        dwpd_pkg::out_beat_t          owed_drives [$];
        int                           mismatches;

        function new();
            regs.target_count = dwpd_pkg::RST_TARGET_COUNT;
            regs.deadband     = dwpd_pkg::RST_DEADBAND;
            regs.gain_p       = dwpd_pkg::RST_GAIN_P;
            regs.gain_i       = dwpd_pkg::RST_GAIN_I;
            regs.gain_d       = dwpd_pkg::RST_GAIN_D;
            regs.base_duty    = dwpd_pkg::RST_BASE_DUTY;
            for (int k = 0; k < 2; k++) begin
                prev_err[k]  = 0;
                err_total[k] = 0;
                held[k]      = '0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [dwpd_pkg::CFG_IDX_W-1:0] idx,
                                logic [dwpd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dwpd_pkg::REG_TARGET_COUNT:
                    regs.target_count = data[dwpd_pkg::COUNT_BITS-1:0];
                dwpd_pkg::REG_DEADBAND:  regs.deadband  = data[dwpd_pkg::DB_W-1:0];
                dwpd_pkg::REG_GAIN_P:    regs.gain_p    = data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_GAIN_I:    regs.gain_i    = data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_GAIN_D:    regs.gain_d    = data[dwpd_pkg::GAIN_W-1:0];
                dwpd_pkg::REG_BASE_DUTY: regs.base_duty = data[dwpd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q16(longint v);
            if (v < 0) return 0;
            if (v > dwpd_pkg::ONE_Q16) return dwpd_pkg::ONE_Q16;
            return v;
        endfunction

        // one side of the controller: p, d and i terms, clamped sum, scaled duty
        function logic [dwpd_pkg::DRIVE_W-1:0] wheel_trim(int side, longint err);
            longint kp, ki, kd, duty, p_term, d_term, i_term, total, drv, lim;
            kp     = regs.gain_p;
            ki     = regs.gain_i;
            kd     = regs.gain_d;
            duty   = regs.base_duty;
            p_term = clamp_q16(kp * err);
            d_term = kd * (err - prev_err[side]);
            i_term = ki * err_total[side];
            drv    = (duty * (dwpd_pkg::ONE_Q16 + clamp_q16(p_term + d_term + i_term)))
                     >>> dwpd_pkg::FRAC_BITS;
            lim    = (64'sd1 <<< (dwpd_pkg::ACCUM_BITS - 1)) - 1;
            total  = err_total[side] + err;
            if (total > lim) total = lim;
            else if (total < -lim - 1) total = -lim - 1;
            prev_err[side]  = err;
            err_total[side] = total;
            return drv[dwpd_pkg::DRIVE_W-1:0];
        endfunction

        function void note_window(dwpd_pkg::in_beat_t b);
            longint              tgt, db, lt, rt, el, er;
            dwpd_pkg::out_beat_t want;
            tgt = regs.target_count;
            db  = regs.deadband;
            lt  = b.left_ticks;
            rt  = b.right_ticks;
            el  = tgt - lt;
            er  = tgt - rt;
            if ((el < 0 ? -el : el) > db || (er < 0 ? -er : er) > db) begin
                held[LEFT]    = wheel_trim(LEFT, el);
                held[RIGHT]   = wheel_trim(RIGHT, er);
                want.adjusted = 1'b1;
            end else begin
                want.adjusted = 1'b0;
            end
            want.left_drive  = held[LEFT];
            want.right_drive = held[RIGHT];
            owed_drives.push_back(want);
        endfunction

        function void check_drive(dwpd_pkg::out_beat_t got);
            dwpd_pkg::out_beat_t want;
            if (owed_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("drive beat with none owed: left=%0d right=%0d adjusted=%0b",
                             got.left_drive, got.right_drive, got.adjusted);
                return;
            end
            want = owed_drives.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                got.adjusted !== want.adjusted) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("drive mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                             want.left_drive, want.right_drive, want.adjusted,
                             got.left_drive, got.right_drive, got.adjusted);
            end
        endfunction

        function int pending();
            return owed_drives.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    dwpd_pkg::in_beat_t              s_data;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    dwpd_pkg::out_beat_t             m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dwpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dwpd_pkg::CFG_DATA_W-1:0] cfg_data;

    wheel_drive_book_t drives = new();

    int       cycles = 0;
    int       burst_left = 0;   // beats left in the current sender burst
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic [7:0] rx_pattern = 8'hff;

    dual_wheel_pid_drive_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[dual_wheel_pid_drive_unit] ERROR");
            $finish;
        end
    end

    // result side: check each accepted beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            drives.check_drive(m_data);
        if (rx_left == 0) begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            rx_left    = $urandom_range(8, 120);
            rx_pattern = 8'($urandom);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                // rotating stall pattern, may hold ready low for a whole stretch
                m_ready    <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            end
        endcase
    end

    // one window beat; valid stays high into the next beat unless a gap starts
    task automatic push_window(input int lt, input int rt);
        dwpd_pkg::in_beat_t b;
        b.left_ticks  = lt[dwpd_pkg::COUNT_BITS-1:0];
        b.right_ticks = rt[dwpd_pkg::COUNT_BITS-1:0];
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        drives.note_window(b);
        burst_left--;
        if (burst_left <= 0) begin
            // sender gap of random length, so valid never drops and rises in one step
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // stop sending and wait for every owed beat, then let the pipe go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (drives.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes the six registers back to back, optionally poking the spare indexes too
    task automatic load_config(input logic [dwpd_pkg::CFG_DATA_W-1:0] tgt,
                               input logic [dwpd_pkg::CFG_DATA_W-1:0] db,
                               input logic [dwpd_pkg::CFG_DATA_W-1:0] gp,
                               input logic [dwpd_pkg::CFG_DATA_W-1:0] gi,
                               input logic [dwpd_pkg::CFG_DATA_W-1:0] gd,
                               input logic [dwpd_pkg::CFG_DATA_W-1:0] bd,
                               input bit poke_spare);
        logic [dwpd_pkg::CFG_IDX_W-1:0]  idx [8];
        logic [dwpd_pkg::CFG_DATA_W-1:0] val [8];
        int                              n;
        idx = '{dwpd_pkg::REG_TARGET_COUNT, dwpd_pkg::REG_DEADBAND, dwpd_pkg::REG_GAIN_P,
                dwpd_pkg::REG_GAIN_I, dwpd_pkg::REG_GAIN_D, dwpd_pkg::REG_BASE_DUTY,
                REG_SPARE_A, REG_SPARE_B};
        val = '{tgt, db, gp, gi, gd, bd, 16'($urandom), 16'($urandom)};
        n   = poke_spare ? 8 : 6;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            drives.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // in-range value most of the time, otherwise a raw random word that may set upper bits
    function automatic logic [dwpd_pkg::CFG_DATA_W-1:0] cfg_word(input int in_range);
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return in_range[dwpd_pkg::CFG_DATA_W-1:0];
    endfunction

    // ticks for a random window: extremes, near the deadband edge, or anywhere
    function automatic int pick_ticks(input int tgt, input int db);
        int off;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return TICK_MAX;
            2, 3, 4: begin
                off = $urandom_range(0, db + 2);
                if ($urandom_range(0, 1)) off = -off;
                off = tgt + off;
                if (off < 0) off = 0;
                if (off > TICK_MAX) off = TICK_MAX;
                return off;
            end
            default: return $urandom_range(0, TICK_MAX);
        endcase
    endfunction

    initial begin
        int tgt, db;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: nothing adjusted yet, so held drives are zero
        push_window(50, 50);
        push_window(53, 47);     // both errors exactly on the deadband edge
        push_window(54, 50);
        push_window(50, 50);     // inside again, held drives repeat
        push_window(0, 0);
        push_window(TICK_MAX, TICK_MAX);
        push_window(0, TICK_MAX);
        push_window(TICK_MAX, 0);
        push_window(46, 50);
        push_window(50, 53);
        settle();

        // every register at its top, base duty past the nominal range
        load_config(TICK_MAX, 255, 16'hffff, 16'hffff, 16'hffff, 16'h3fff, 1'b0);
        push_window(TICK_MAX, TICK_MAX);
        push_window(768, 768);   // error 255, still held
        push_window(767, TICK_MAX);
        push_window(0, 0);
        push_window(TICK_MAX, 0);
        push_window(512, 900);
        settle();

        // every register at zero, plus writes to the spare indexes that must be dropped
        load_config(0, 0, 0, 0, 0, 0, 1'b1);
        push_window(0, 0);
        push_window(1, 0);
        push_window(TICK_MAX, TICK_MAX);
        push_window(0, TICK_MAX);
        settle();

        // random settings, random windows, idling on both sides
        for (int ph = 0; ph < 6; ph++) begin
            load_config(cfg_word(($urandom_range(0, 3) == 0) ? TICK_MAX * $urandom_range(0, 1)
                                                             : $urandom_range(0, TICK_MAX)),
                        cfg_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 12)),
                        cfg_word($urandom_range(0, 1) ? $urandom_range(0, 4000)
                                                      : $urandom_range(0, 65535)),
                        cfg_word($urandom_range(0, 1) ? $urandom_range(0, 800)
                                                      : $urandom_range(0, 65535)),
                        cfg_word($urandom_range(0, 1) ? $urandom_range(0, 12000)
                                                      : $urandom_range(0, 65535)),
                        cfg_word(($urandom_range(0, 3) == 0) ? 10000 : $urandom_range(0, 16383)),
                        ($urandom_range(0, 2) == 0));
            tgt = drives.regs.target_count;
            db  = drives.regs.deadband;
            for (int k = 0; k < 150; k++)
                push_window(pick_ticks(tgt, db), pick_ticks(tgt, db));
            settle();
        end

        if (drives.mismatches == 0 && drives.pending() == 0)
            $display("[dual_wheel_pid_drive_unit] OK");
        else
            $display("[dual_wheel_pid_drive_unit] ERROR");
        $finish;
    end

endmodule
